### hw/rtl/ppurp_pkg.sv
// ----------------------------------------------------------------------------
// ppurp_pkg
// Shared constants for the picture processor CPU register port.
// ----------------------------------------------------------------------------
package ppurp_pkg;

   localparam int NAMETABLE_BYTES_DEF = 2048;
   localparam int SPRITE_BYTES        = 256;
   localparam int PALETTE_BYTES       = 32;
   localparam int SPR_AW              = $clog2(SPRITE_BYTES);
   localparam int PAL_AW              = $clog2(PALETTE_BYTES);

   // transaction kinds (req_tuser)
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;
   localparam logic [1:0] KIND_DMA   = 2'd3;

   // register numbers
   localparam logic [2:0] REG_CTRL    = 3'd0;
   localparam logic [2:0] REG_MASK    = 3'd1;
   localparam logic [2:0] REG_STATUS  = 3'd2;
   localparam logic [2:0] REG_OAMADDR = 3'd3;
   localparam logic [2:0] REG_OAMDATA = 3'd4;
   localparam logic [2:0] REG_SCROLL  = 3'd5;
   localparam logic [2:0] REG_ADDR    = 3'd6;
   localparam logic [2:0] REG_DATA    = 3'd7;

   // result status
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOACC   = 3'd1;
   localparam logic [2:0] ST_CHR     = 3'd2;
   localparam logic [2:0] ST_BIGTICK = 3'd3;

   // configuration register indexes
   localparam logic CFG_MIRRORING = 1'b0;
   localparam logic CFG_WARMUP    = 1'b1;

   localparam logic [14:0] WARMUP_RESET    = 15'd30000;
   localparam logic [10:0] DOTS_PER_LINE   = 11'd341;
   localparam logic [10:0] TICK_LIMIT      = 11'd682;
   localparam logic [8:0]  VBLANK_LINE     = 9'd241;
   localparam logic [8:0]  LINES_PER_FRAME = 9'd262;
   localparam logic [13:0] NT_TOP          = 14'h3EFF;
   localparam logic [13:0] STEP_ROW        = 14'd32;
   localparam logic [13:0] STEP_ONE        = 14'd1;

endpackage

### hw/rtl/ppurp_ram.sv
// ----------------------------------------------------------------------------
// ppurp_ram
// Byte-wide synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ppurp_ram #(
   parameter  int DEPTH = ppurp_pkg::SPRITE_BYTES,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/ppurp_core.sv
// ----------------------------------------------------------------------------
// ppurp_core
// Register file, timing counters and transaction sequencer; drives the RAMs.
// ----------------------------------------------------------------------------
module ppurp_core #(
   parameter  int NAMETABLE_BYTES = ppurp_pkg::NAMETABLE_BYTES_DEF,
   localparam int NT_AW           = $clog2(NAMETABLE_BYTES)
) (
   input  logic                        clock,
   input  logic                        reset,
   // request
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [31:0]                 req_tdata,
   input  logic [1:0]                  req_tuser,
   // response
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [15:0]                 rsp_tdata,
   // configuration
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_index,
   input  logic [14:0]                 csr_data,
   // name table RAM
   output logic                        nt_wr_en,
   output logic [NT_AW-1:0]            nt_wr_addr,
   output logic [7:0]                  nt_wr_data,
   output logic [NT_AW-1:0]            nt_rd_addr,
   input  logic [7:0]                  nt_rd_data,
   // palette RAM
   output logic                        pal_wr_en,
   output logic [ppurp_pkg::PAL_AW-1:0] pal_wr_addr,
   output logic [7:0]                  pal_wr_data,
   output logic [ppurp_pkg::PAL_AW-1:0] pal_rd_addr,
   input  logic [7:0]                  pal_rd_data,
   // sprite RAM
   output logic                        spr_wr_en,
   output logic [ppurp_pkg::SPR_AW-1:0] spr_wr_addr,
   output logic [7:0]                  spr_wr_data,
   output logic [ppurp_pkg::SPR_AW-1:0] spr_rd_addr,
   input  logic [7:0]                  spr_rd_data
);

   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_IDLE  = 3'b010,
      S_EXEC  = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [NT_AW-1:0] clr_ff, clr_in;

   logic        mirroring_ff, mirroring_in;
   logic [14:0] warmup_cycles_ff, warmup_cycles_in;

   logic [7:0]  control_ff, control_in;
   logic [7:0]  mask_ff, mask_in;
   logic        vblank_ff, vblank_in;
   logic [7:0]  oam_ptr_ff, oam_ptr_in;
   logic [13:0] vram_ptr_ff, vram_ptr_in;
   logic [7:0]  read_buf_ff, read_buf_in;
   logic [14:0] warmup_ff, warmup_in;
   logic [8:0]  scanline_ff, scanline_in;
   logic [8:0]  line_dot_ff, line_dot_in;

   // latched transaction
   logic [1:0]  kind_ff;
   logic [2:0]  reg_ff;
   logic [7:0]  val_ff;
   logic [9:0]  cyc_ff;
   logic [7:0]  dma_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;

   logic        accept, fire, clearing;
   logic [7:0]  rd;
   logic        nmi;
   logic [2:0]  st;
   logic        nt_wr, pal_wr, spr_wr, spr_dma;
   logic        chr, is_pal;
   logic [10:0] nt_idx;
   logic [13:0] step_amt;
   logic [10:0] dot_sum;
   logic [15:0] warm_sum;
   logic [8:0]  scanline_inc;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign fire       = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign clearing   = (state_ff == S_CLEAR);

   // address decode of the VRAM pointer
   assign chr      = !vram_ptr_ff[13];
   assign is_pal   = vram_ptr_ff > ppurp_pkg::NT_TOP;
   assign nt_idx   = mirroring_ff ? vram_ptr_ff[10:0] : {vram_ptr_ff[11], vram_ptr_ff[9:0]};
   assign step_amt = control_ff[1] ? ppurp_pkg::STEP_ROW : ppurp_pkg::STEP_ONE;
   assign dot_sum  = {2'b00, line_dot_ff} + {1'b0, cyc_ff};
   assign warm_sum = {1'b0, warmup_ff} + {6'd0, cyc_ff};
   assign scanline_inc = scanline_ff + 9'd1;

   always_comb begin
      state_in         = state_ff;
      clr_in           = clr_ff;
      mirroring_in     = mirroring_ff;
      warmup_cycles_in = warmup_cycles_ff;
      control_in       = control_ff;
      mask_in          = mask_ff;
      vblank_in        = vblank_ff;
      oam_ptr_in       = oam_ptr_ff;
      vram_ptr_in      = vram_ptr_ff;
      read_buf_in      = read_buf_ff;
      warmup_in        = warmup_ff;
      scanline_in      = scanline_ff;
      line_dot_in      = line_dot_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;
      rd      = 8'd0;
      nmi     = 1'b0;
      st      = ppurp_pkg::ST_OK;
      nt_wr   = 1'b0;
      pal_wr  = 1'b0;
      spr_wr  = 1'b0;
      spr_dma = 1'b0;

      if (csr_valid) begin
         if (csr_index == ppurp_pkg::CFG_MIRRORING) begin
            mirroring_in = csr_data[0];
         end else begin
            warmup_cycles_in = csr_data;
         end
      end

      case (kind_ff)
         ppurp_pkg::KIND_TICK: begin
            if (dot_sum >= ppurp_pkg::TICK_LIMIT) begin
               st = ppurp_pkg::ST_BIGTICK;
            end else begin
               warmup_in = (warm_sum > {1'b0, warmup_cycles_ff}) ? warmup_cycles_ff
                                                               : warm_sum[14:0];
               if (dot_sum >= ppurp_pkg::DOTS_PER_LINE) begin
                  line_dot_in = 9'(dot_sum - ppurp_pkg::DOTS_PER_LINE);
                  scanline_in = scanline_inc;
                  if (scanline_inc == ppurp_pkg::VBLANK_LINE) begin
                     nmi       = 1'b1;
                     vblank_in = 1'b1;
                  end else if (scanline_inc >= ppurp_pkg::LINES_PER_FRAME) begin
                     scanline_in = 9'd0;
                     vblank_in   = 1'b0;
                  end
               end else begin
                  line_dot_in = dot_sum[8:0];
               end
            end
         end
         ppurp_pkg::KIND_READ: begin
            case (reg_ff)
               ppurp_pkg::REG_STATUS: begin
                  rd        = {vblank_ff, 7'd0};
                  vblank_in = 1'b0;
               end
               ppurp_pkg::REG_OAMDATA: rd = spr_rd_data;
               ppurp_pkg::REG_DATA: begin
                  if (chr) begin
                     st = ppurp_pkg::ST_CHR;
                  end else begin
                     rd          = read_buf_ff;
                     read_buf_in = is_pal ? pal_rd_data : nt_rd_data;
                     vram_ptr_in = vram_ptr_ff + step_amt;
                  end
               end
               default: st = ppurp_pkg::ST_NOACC;
            endcase
         end
         ppurp_pkg::KIND_WRITE: begin
            case (reg_ff)
               ppurp_pkg::REG_CTRL: begin
                  if (warmup_ff >= warmup_cycles_ff) begin
                     control_in = val_ff;
                  end
               end
               ppurp_pkg::REG_MASK:    mask_in = val_ff;
               ppurp_pkg::REG_OAMADDR: oam_ptr_in = val_ff;
               ppurp_pkg::REG_OAMDATA: begin
                  spr_wr     = 1'b1;
                  oam_ptr_in = oam_ptr_ff + 8'd1;
               end
               ppurp_pkg::REG_SCROLL: ;
               ppurp_pkg::REG_ADDR: vram_ptr_in = {vram_ptr_ff[5:0], val_ff};
               ppurp_pkg::REG_DATA: begin
                  if (chr) begin
                     st = ppurp_pkg::ST_CHR;
                  end else begin
                     nt_wr       = !is_pal;
                     pal_wr      = is_pal;
                     vram_ptr_in = vram_ptr_ff + step_amt;
                  end
               end
               default: st = ppurp_pkg::ST_NOACC;
            endcase
         end
         default: begin
            spr_wr  = 1'b1;
            spr_dma = 1'b1;
         end
      endcase

      if (!fire) begin
         // keep only configuration updates
         control_in  = control_ff;
         mask_in     = mask_ff;
         vblank_in   = vblank_ff;
         oam_ptr_in  = oam_ptr_ff;
         vram_ptr_in = vram_ptr_ff;
         read_buf_in = read_buf_ff;
         warmup_in   = warmup_ff;
         scanline_in = scanline_ff;
         line_dot_in = line_dot_ff;
         nt_wr       = 1'b0;
         pal_wr      = 1'b0;
         spr_wr      = 1'b0;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + NT_AW'(1);
            if (clr_ff == NT_AW'(NAMETABLE_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (fire) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, st, nmi, rd};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         clr_ff           <= '0;
         mirroring_ff     <= 1'b0;
         warmup_cycles_ff <= ppurp_pkg::WARMUP_RESET;
         control_ff       <= 8'd0;
         mask_ff          <= 8'd0;
         vblank_ff        <= 1'b0;
         oam_ptr_ff       <= 8'd0;
         vram_ptr_ff      <= 14'd0;
         read_buf_ff      <= 8'd0;
         warmup_ff        <= 15'd0;
         scanline_ff      <= 9'd0;
         line_dot_ff      <= 9'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clr_ff           <= clr_in;
         mirroring_ff     <= mirroring_in;
         warmup_cycles_ff <= warmup_cycles_in;
         control_ff       <= control_in;
         mask_ff          <= mask_in;
         vblank_ff        <= vblank_in;
         oam_ptr_ff       <= oam_ptr_in;
         vram_ptr_ff      <= vram_ptr_in;
         read_buf_ff      <= read_buf_in;
         warmup_ff        <= warmup_in;
         scanline_ff      <= scanline_in;
         line_dot_ff      <= line_dot_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         kind_ff <= req_tuser;
         reg_ff  <= req_tdata[2:0];
         val_ff  <= req_tdata[10:3];
         cyc_ff  <= req_tdata[20:11];
         dma_ff  <= req_tdata[28:21];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // RAM ports: reads always track the current pointers, clearing sweep owns writes
   assign nt_rd_addr  = NT_AW'(nt_idx);
   assign pal_rd_addr = vram_ptr_ff[ppurp_pkg::PAL_AW-1:0];
   assign spr_rd_addr = oam_ptr_ff;

   assign nt_wr_en    = clearing || nt_wr;
   assign nt_wr_addr  = clearing ? clr_ff : NT_AW'(nt_idx);
   assign nt_wr_data  = clearing ? 8'd0 : val_ff;

   assign pal_wr_en   = clearing || pal_wr;
   assign pal_wr_addr = clearing ? clr_ff[ppurp_pkg::PAL_AW-1:0]
                                 : vram_ptr_ff[ppurp_pkg::PAL_AW-1:0];
   assign pal_wr_data = clearing ? 8'd0 : val_ff;

   assign spr_wr_en   = clearing || spr_wr;
   assign spr_wr_addr = clearing ? clr_ff[ppurp_pkg::SPR_AW-1:0]
                                 : (spr_dma ? dma_ff : oam_ptr_ff);
   assign spr_wr_data = clearing ? 8'd0 : val_ff;

   // mask register is write-only state with no readback path
   logic mask_unused;
   assign mask_unused = ^mask_ff;

endmodule

### hw/rtl/ppu_register_port_and_vblank_unit.sv
// ----------------------------------------------------------------------------
// ppu_register_port_and_vblank_unit
// CPU register port of a picture processor with dot/scanline timing and vblank.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  req_     | in        | req_tvalid/req_tready  | tuser kind, tdata item fields
//  rsp_     | out       | rsp_tvalid/rsp_tready  | tdata read_data, nmi_pulse, status
//  csr_     | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// Each transaction issues a registered RAM read from the current pointers, then
// does the read-modify-write and result capture in the execute state.
// After reset a clearing pass over every name table address zeroes all RAMs;
// req_tready is low meanwhile. A stalled response holds in the output register
// while the next transaction is accepted; that one waits in execute.
// ----------------------------------------------------------------------------
module ppu_register_port_and_vblank_unit #(
   parameter int NAMETABLE_BYTES = ppurp_pkg::NAMETABLE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // reg_index, write_value, tick_cycles, dma_index
   input  logic [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // read_data, nmi_pulse, status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [14:0] csr_data
);

   localparam int NT_AW = $clog2(NAMETABLE_BYTES);

   logic                         nt_wr_en;
   logic [NT_AW-1:0]             nt_wr_addr, nt_rd_addr;
   logic [7:0]                   nt_wr_data, nt_rd_data;
   logic                         pal_wr_en;
   logic [ppurp_pkg::PAL_AW-1:0] pal_wr_addr, pal_rd_addr;
   logic [7:0]                   pal_wr_data, pal_rd_data;
   logic                         spr_wr_en;
   logic [ppurp_pkg::SPR_AW-1:0] spr_wr_addr, spr_rd_addr;
   logic [7:0]                   spr_wr_data, spr_rd_data;

   ppurp_core #(.NAMETABLE_BYTES(NAMETABLE_BYTES)) u_core (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .nt_wr_en    (nt_wr_en),
      .nt_wr_addr  (nt_wr_addr),
      .nt_wr_data  (nt_wr_data),
      .nt_rd_addr  (nt_rd_addr),
      .nt_rd_data  (nt_rd_data),
      .pal_wr_en   (pal_wr_en),
      .pal_wr_addr (pal_wr_addr),
      .pal_wr_data (pal_wr_data),
      .pal_rd_addr (pal_rd_addr),
      .pal_rd_data (pal_rd_data),
      .spr_wr_en   (spr_wr_en),
      .spr_wr_addr (spr_wr_addr),
      .spr_wr_data (spr_wr_data),
      .spr_rd_addr (spr_rd_addr),
      .spr_rd_data (spr_rd_data)
   );

   ppurp_ram #(.DEPTH(NAMETABLE_BYTES)) u_nt_ram (
      .clock   (clock),
      .wr_en   (nt_wr_en),
      .wr_addr (nt_wr_addr),
      .wr_data (nt_wr_data),
      .rd_addr (nt_rd_addr),
      .rd_data (nt_rd_data)
   );

   ppurp_ram #(.DEPTH(ppurp_pkg::PALETTE_BYTES)) u_pal_ram (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (pal_wr_addr),
      .wr_data (pal_wr_data),
      .rd_addr (pal_rd_addr),
      .rd_data (pal_rd_data)
   );

   ppurp_ram #(.DEPTH(ppurp_pkg::SPRITE_BYTES)) u_spr_ram (
      .clock   (clock),
      .wr_en   (spr_wr_en),
      .wr_addr (spr_wr_addr),
      .wr_data (spr_wr_data),
      .rd_addr (spr_rd_addr),
      .rd_data (spr_rd_data)
   );

   a_reset_clears : assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request accepted during RAM clearing");

   a_one_at_a_time : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second transaction accepted while one executes");

   a_nmi_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[8]) |->
      (rsp_tdata[11:9] == ppurp_pkg::ST_OK && rsp_tdata[7:0] == 8'd0))
      else $error("nmi with error status or read data");

   a_err_no_data : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[11:9] == ppurp_pkg::ST_CHR ||
                      rsp_tdata[11:9] == ppurp_pkg::ST_NOACC ||
                      rsp_tdata[11:9] == ppurp_pkg::ST_BIGTICK)) |->
      (rsp_tdata[7:0] == 8'd0 && !rsp_tdata[8]))
      else $error("error response carries data");

endmodule
